@@ sv/rfifo_pkg.sv @@
// ----------------------------------------------------------------------------
// rfifo_pkg
// Shared types, sizes and index helpers for the ring FIFO with peek and
// burst read.
// ----------------------------------------------------------------------------
package rfifo_pkg;

  localparam int CAPACITY = 16;
  localparam int SLOTS    = CAPACITY + 1;
  localparam int MAX_OUT  = 16;

  localparam int DATA_W = 32;
  localparam int POS_W  = 5;
  localparam int CNT_W  = 5;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int LEN_W  = $clog2(CAPACITY + 1);
  localparam int REM_W  = $clog2(MAX_OUT + 1);
  // Wide enough for an index plus any position, and for length/count compares.
  localparam int SUM_W  = ((IDX_W > POS_W) ? IDX_W : POS_W) + 1
                          + ((LEN_W > CNT_W) ? LEN_W : CNT_W);

  typedef enum logic [1:0] {
    CMD_PUT  = 2'd0,
    CMD_GET  = 2'd1,
    CMD_PEEK = 2'd2,
    CMD_COPY = 2'd3
  } cmd_t;

  typedef struct packed {
    cmd_t                     command;
    logic signed [DATA_W-1:0] value;
    logic [POS_W-1:0]         position;
    logic [CNT_W-1:0]         count;
  } in_item_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] data;
    logic                     ok;
    logic [LEN_W-1:0]         length;
    logic                     last;
  } out_item_t;

  // Next slot around the ring.
  function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] res;
    if (idx == IDX_W'(SLOTS - 1)) begin
      res = '0;
    end else begin
      res = idx + IDX_W'(1);
    end
    return res;
  endfunction

  // Slot at an offset from idx. The offset is below the length whenever the
  // result is used, so one conditional subtract wraps it.
  function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] idx,
                                               input logic [POS_W-1:0] off);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(idx) + SUM_W'(off);
    if (sum >= SUM_W'(SLOTS)) begin
      sum = sum - SUM_W'(SLOTS);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

@@ sv/ring_fifo_with_peek_and_burst_read.sv @@
// ----------------------------------------------------------------------------
// ring_fifo_with_peek_and_burst_read
// Ring FIFO of signed 32-bit words with get, put, peek and burst copy.
// ----------------------------------------------------------------------------
// Usage: commands arrive on the in_ channel (valid/stall); each is put, get,
// peek at a position from the oldest word, or a burst copy of up to count
// words from a position. Results leave on the out_ channel, one per command,
// or one per copied word with last set on the final one. Every result carries
// the length after the command. Failing commands (full, empty, out of range,
// copy of nothing) give one result with ok low and data zero.
// Words live in a 17-entry RAM with a registered read port. For a put, or
// any failing command, the result is registered directly and is valid the
// cycle after acceptance. A get or peek first reads the RAM, then registers
// the result. A copy reads the RAM once per word, streaming one word per
// cycle into the output register unless out_ stalls. One command is in
// flight at a time; the next is taken once idle with the result reg free.
// A stall on out_ holds the result register and the RAM read data, so the
// stream pauses and resumes without loss. Reset empties the FIFO; the RAM
// contents are not cleared, as only written slots are ever read.
// ----------------------------------------------------------------------------
module ring_fifo_with_peek_and_burst_read (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  rfifo_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output rfifo_pkg::out_item_t out_item
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_t;

  state_t                         state_r, state_nxt;
  logic [rfifo_pkg::IDX_W-1:0]    wr_idx_r, wr_idx_nxt;
  logic [rfifo_pkg::IDX_W-1:0]    rd_idx_r, rd_idx_nxt;
  logic [rfifo_pkg::LEN_W-1:0]    len_r, len_nxt;
  logic [rfifo_pkg::REM_W-1:0]    rem_r, rem_nxt;
  logic [rfifo_pkg::IDX_W-1:0]    addr_r, addr_nxt;
  logic [rfifo_pkg::LEN_W-1:0]    olen_r, olen_nxt;
  logic                           out_valid_r, out_valid_nxt;
  rfifo_pkg::out_item_t           out_item_r, out_item_nxt;

  logic                           in_fire;
  logic                           out_free;
  logic                           ram_we;
  logic                           ram_re;
  logic [rfifo_pkg::IDX_W-1:0]    ram_raddr;
  logic [rfifo_pkg::DATA_W-1:0]   ram_rdata;
  logic                           pos_in;
  logic [rfifo_pkg::IDX_W-1:0]    pos_addr;
  logic [rfifo_pkg::SUM_W-1:0]    avail;
  logic [rfifo_pkg::SUM_W-1:0]    copy_n;
  logic [rfifo_pkg::LEN_W-1:0]    ptr_len;

  rfifo_ram #(
    .WIDTH (rfifo_pkg::DATA_W),
    .DEPTH (rfifo_pkg::SLOTS)
  ) u_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (wr_idx_r),
    .wr_data (in_item.value),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign in_fire  = in_valid && !in_stall;

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  // Peek and copy addressing, and the clamped copy length.
  always_comb begin
    pos_in   = rfifo_pkg::SUM_W'(in_item.position) < rfifo_pkg::SUM_W'(len_r);
    pos_addr = rfifo_pkg::idx_add(rd_idx_r, in_item.position);
    avail    = pos_in ? (rfifo_pkg::SUM_W'(len_r) - rfifo_pkg::SUM_W'(in_item.position))
                      : '0;
    copy_n   = avail;
    if (rfifo_pkg::SUM_W'(in_item.count) < copy_n) begin
      copy_n = rfifo_pkg::SUM_W'(in_item.count);
    end
    if (copy_n > rfifo_pkg::SUM_W'(rfifo_pkg::MAX_OUT)) begin
      copy_n = rfifo_pkg::SUM_W'(rfifo_pkg::MAX_OUT);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    wr_idx_nxt    = wr_idx_r;
    rd_idx_nxt    = rd_idx_r;
    len_nxt       = len_r;
    rem_nxt       = rem_r;
    addr_nxt      = addr_r;
    olen_nxt      = olen_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = addr_r;

    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          // Default to a failure result produced right away.
          out_item_nxt.data   = '0;
          out_item_nxt.ok     = 1'b0;
          out_item_nxt.length = len_r;
          out_item_nxt.last   = 1'b1;
          out_valid_nxt       = 1'b1;
          case (in_item.command)
            rfifo_pkg::CMD_PUT: begin
              if (len_r < rfifo_pkg::LEN_W'(rfifo_pkg::CAPACITY)) begin
                ram_we              = 1'b1;
                wr_idx_nxt          = rfifo_pkg::idx_inc(wr_idx_r);
                len_nxt             = len_r + rfifo_pkg::LEN_W'(1);
                out_item_nxt.ok     = 1'b1;
                out_item_nxt.length = len_r + rfifo_pkg::LEN_W'(1);
              end
            end
            rfifo_pkg::CMD_GET: begin
              if (len_r != '0) begin
                ram_re        = 1'b1;
                ram_raddr     = rd_idx_r;
                rd_idx_nxt    = rfifo_pkg::idx_inc(rd_idx_r);
                len_nxt       = len_r - rfifo_pkg::LEN_W'(1);
                olen_nxt      = len_r - rfifo_pkg::LEN_W'(1);
                rem_nxt       = rfifo_pkg::REM_W'(1);
                state_nxt     = S_READ;
                out_item_nxt  = out_item_r;
                out_valid_nxt = out_valid_r && out_stall;
              end
            end
            rfifo_pkg::CMD_PEEK: begin
              if (pos_in) begin
                ram_re        = 1'b1;
                ram_raddr     = pos_addr;
                olen_nxt      = len_r;
                rem_nxt       = rfifo_pkg::REM_W'(1);
                state_nxt     = S_READ;
                out_item_nxt  = out_item_r;
                out_valid_nxt = out_valid_r && out_stall;
              end
            end
            rfifo_pkg::CMD_COPY: begin
              if (copy_n != '0) begin
                ram_re        = 1'b1;
                ram_raddr     = pos_addr;
                addr_nxt      = rfifo_pkg::idx_inc(pos_addr);
                olen_nxt      = len_r;
                rem_nxt       = copy_n[rfifo_pkg::REM_W-1:0];
                state_nxt     = S_READ;
                out_item_nxt  = out_item_r;
                out_valid_nxt = out_valid_r && out_stall;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        // RAM data for the current word is ready; move it out when the
        // result register frees up and fetch the next word unless this is the last.
        if (out_free) begin
          out_valid_nxt       = 1'b1;
          out_item_nxt.data   = $signed(ram_rdata);
          out_item_nxt.ok     = 1'b1;
          out_item_nxt.length = olen_r;
          out_item_nxt.last   = (rem_r == rfifo_pkg::REM_W'(1));
          if (rem_r == rfifo_pkg::REM_W'(1)) begin
            state_nxt = S_IDLE;
          end else begin
            ram_re    = 1'b1;
            ram_raddr = addr_r;
            addr_nxt  = rfifo_pkg::idx_inc(addr_r);
            rem_nxt   = rem_r - rfifo_pkg::REM_W'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      len_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wr_idx_r    <= wr_idx_nxt;
      rd_idx_r    <= rd_idx_nxt;
      len_r       <= len_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    olen_r     <= olen_nxt;
    out_item_r <= out_item_nxt;
  end

  // Length as implied by the two ring pointers.
  always_comb begin
    if (wr_idx_r >= rd_idx_r) begin
      ptr_len = rfifo_pkg::LEN_W'(wr_idx_r - rd_idx_r);
    end else begin
      ptr_len = rfifo_pkg::LEN_W'(rfifo_pkg::SUM_W'(wr_idx_r)
                + rfifo_pkg::SUM_W'(rfifo_pkg::SLOTS) - rfifo_pkg::SUM_W'(rd_idx_r));
    end
  end

  a_len_matches_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    len_r == ptr_len)
    else $error("length counter disagrees with ring pointers");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= rfifo_pkg::LEN_W'(rfifo_pkg::CAPACITY))
    else $error("length above capacity");

  a_read_has_work: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |-> (rem_r != '0))
    else $error("read state with no words left");

  a_burst_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_item_r.last) |=> out_valid_r)
    else $error("burst stream dropped its valid before the last word");

endmodule

@@ sv/rfifo_ram.sv @@
// ----------------------------------------------------------------------------
// rfifo_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rfifo_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 17
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // Read data holds while no read is issued.
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
